/* rtl/ita_pkg.sv */
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types and constants of the radix integer-to-ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ita_pkg;

    // Field widths of the request and result items and of a stored digit
    localparam int VALUE_W = 64;
    localparam int RADIX_W = 5;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;

    // Defaults for top-level parameters
    localparam int VALUE_BITS_DEF  = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic               treat_signed;
        logic               upper_case;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
    } out_item_t;

endpackage

`default_nettype wire

/* rtl/radix_integer_to_ascii_top.sv */
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_top
// Converts a number to ASCII digits in radix 2 to 16, most significant first.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    ita_pkg::in_item_t  (one number)
//   m_       out  m_valid/m_ready    ita_pkg::out_item_t (one digit)
//
// The radix divider retires one quotient bit per cycle, and each digit is then
// read back in turn through the registered digit memory read.
// The front and the job queue keep accepting numbers while the engine works, until the queue is full.
// A stalled m_ready holds the current digit and pauses digit readout only.
// Reset (aresetn, synchronous) empties the queue and returns the engine idle.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_integer_to_ascii_top #(
    parameter int VALUE_BITS  = ita_pkg::VALUE_BITS_DEF,
    parameter int QUEUE_DEPTH = ita_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ita_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ita_pkg::out_item_t      m_item
);

    localparam int JOB_W = VALUE_BITS + ita_pkg::RADIX_W + 1;

    logic             fr_valid;
    logic             fr_ready;
    logic [JOB_W-1:0] fr_data;
    logic             q_valid;
    logic             q_ready;
    logic [JOB_W-1:0] q_data;

    ita_front #(
        .VALUE_BITS (VALUE_BITS),
        .JOB_W      (JOB_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .job_valid (fr_valid),
        .job_ready (fr_ready),
        .job_data  (fr_data)
    );

    ita_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    ita_back #(
        .VALUE_BITS (VALUE_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job_data  (q_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire

/* rtl/ita_front.sv */
// ----------------------------------------------------------------------------
// ita_front
// Accepts requests, clamps the radix and takes the magnitude of negative
// signed values, then hands the job to the queue through a register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ita_front #(
    parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF,
    parameter int JOB_W      = VALUE_BITS + ita_pkg::RADIX_W + 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ita_pkg::in_item_t s_item,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output logic [JOB_W-1:0]       job_data
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [JOB_W-1:0]            job_reg;
    logic [JOB_W-1:0]            job_next;
    logic [VALUE_BITS-1:0]       raw_value;
    logic [VALUE_BITS-1:0]       mag;
    logic [ita_pkg::RADIX_W-1:0] radix_clamped;
    logic                        take;

    assign raw_value = s_item.value[VALUE_BITS-1:0];
    assign s_ready   = !valid_reg || job_ready;
    assign take      = s_valid && s_ready;

    always_comb begin
        // most negative value negates to itself, which is its magnitude
        if (s_item.treat_signed && raw_value[VALUE_BITS-1]) begin
            mag = ~raw_value + VALUE_BITS'(1);
        end else begin
            mag = raw_value;
        end
        priority if (s_item.radix < ita_pkg::RADIX_MIN) begin
            radix_clamped = ita_pkg::RADIX_MIN;
        end else if (s_item.radix > ita_pkg::RADIX_MAX) begin
            radix_clamped = ita_pkg::RADIX_MAX;
        end else begin
            radix_clamped = s_item.radix;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        job_next   = job_reg;
        if (take) begin
            valid_next = 1'b1;
            job_next   = {mag, radix_clamped, s_item.upper_case};
        end else if (job_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        job_reg <= job_next;
    end

    assign job_valid = valid_reg;
    assign job_data  = job_reg;

endmodule

`default_nettype wire

/* rtl/ita_fifo.sv */
// ----------------------------------------------------------------------------
// ita_fifo
// Short job queue between the front and the conversion engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ita_fifo #(
    parameter int WIDTH = 70,
    parameter int DEPTH = ita_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not grow on push");
`endif

endmodule

`default_nettype wire

/* rtl/ita_back.sv */
// ----------------------------------------------------------------------------
// ita_back
// Conversion engine: bit-serial division by the radix yields digits least
// significant first into a digit memory, then reads them back in reverse
// through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ita_back #(
    parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF,
    parameter int JOB_W      = VALUE_BITS + ita_pkg::RADIX_W + 1
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         job_valid,
    output logic              job_ready,
    input  wire logic [JOB_W-1:0] job_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output ita_pkg::out_item_t m_item
);

    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int RW    = ita_pkg::RADIX_W;
    localparam int DW    = ita_pkg::DIGIT_W;
    localparam int CW    = ita_pkg::CHAR_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    localparam logic [CW-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CW-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CW-1:0] CHAR_LOWER_A = 7'h61;

    logic [1:0]            state_reg,   state_next;
    logic [VALUE_BITS-1:0] dvd_reg,     dvd_next;
    logic [RW-1:0]         rem_reg,     rem_next;
    logic [RW-1:0]         radix_reg,   radix_next;
    logic                  upper_reg,   upper_next;
    logic [IDX_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0]      wr_idx_reg,  wr_idx_next;
    logic [IDX_W-1:0]      rd_idx_reg,  rd_idx_next;
    logic                  out_valid_reg, out_valid_next;
    ita_pkg::out_item_t    out_item_reg,  out_item_next;
    logic [DW-1:0]         rd_data_reg;
    logic [DW-1:0]         digit_mem [VALUE_BITS];

    logic [RW-1:0]         shifted;
    logic                  ge;
    logic [RW-1:0]         rem_step;
    logic [VALUE_BITS-1:0] dvd_step;
    logic                  last_bit;
    logic                  mem_we;
    logic                  out_load;
    logic [CW-1:0]         digit_ascii;

    assign job_ready = state_reg == ST_IDLE;

    // one restoring division step
    assign shifted  = {rem_reg[RW-2:0], dvd_reg[VALUE_BITS-1]};
    assign ge       = shifted >= radix_reg;
    assign rem_step = ge ? shifted - radix_reg : shifted;
    assign dvd_step = {dvd_reg[VALUE_BITS-2:0], ge};
    assign last_bit = bit_cnt_reg == IDX_W'(VALUE_BITS - 1);
    assign mem_we   = (state_reg == ST_DIV) && last_bit;
    assign out_load = (state_reg == ST_LOAD) && (!out_valid_reg || m_ready);

    always_comb begin
        if (rd_data_reg < DW'(10)) begin
            digit_ascii = CHAR_ZERO + CW'(rd_data_reg);
        end else begin
            digit_ascii = (upper_reg ? CHAR_UPPER_A : CHAR_LOWER_A)
                          + CW'(rd_data_reg) - CW'(10);
        end
    end

    always_comb begin
        state_next     = state_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        radix_next     = radix_reg;
        upper_next     = upper_reg;
        bit_cnt_next   = bit_cnt_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    dvd_next     = job_data[JOB_W-1 -: VALUE_BITS];
                    radix_next   = job_data[RW:1];
                    upper_next   = job_data[0];
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    wr_idx_next  = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                dvd_next     = dvd_step;
                rem_next     = rem_step;
                bit_cnt_next = bit_cnt_reg + IDX_W'(1);
                if (last_bit) begin
                    // digit is written to memory; restart on the quotient
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    wr_idx_next  = wr_idx_reg + IDX_W'(1);
                    if (dvd_step == '0) begin
                        rd_idx_next = wr_idx_reg;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_load) begin
                    out_valid_next           = 1'b1;
                    out_item_next.digit_char = digit_ascii;
                    out_item_next.last_digit = rd_idx_reg == '0;
                    if (rd_idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg - IDX_W'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        radix_reg    <= radix_next;
        upper_reg    <= upper_next;
        bit_cnt_reg  <= bit_cnt_next;
        wr_idx_reg   <= wr_idx_next;
        rd_idx_reg   <= rd_idx_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            digit_mem[wr_idx_reg] <= rem_step[DW-1:0];
        end
        rd_data_reg <= digit_mem[rd_idx_reg];
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

`ifndef NO_ASSERTIONS
    a_rem_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> rem_reg < radix_reg)
        else $error("partial remainder not below radix");

    a_radix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (radix_reg >= ita_pkg::RADIX_MIN
                                    && radix_reg <= ita_pkg::RADIX_MAX))
        else $error("radix out of range while busy");

    a_last_ends_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && rd_idx_reg == '0) |=> (state_reg == ST_IDLE && m_valid
                                            && m_item.last_digit))
        else $error("final digit did not close the job");
`endif

endmodule

`default_nettype wire
